// ===== rtl/core/mhj_pkg.sv =====
`default_nettype none

package mhj_pkg;

    // Sequencer modes as reported on the result channel.
    typedef enum logic [2:0] {
        MODE_START = 3'd0,
        MODE_IDLE  = 3'd1,
        MODE_HOME  = 3'd2,
        MODE_FWD   = 3'd3,
        MODE_REV   = 3'd4,
        MODE_AUTO  = 3'd5
    } mode_t;

    // Command codes; codes six and seven are unknown.
    localparam logic [2:0] CMD_NONE = 3'd0;
    localparam logic [2:0] CMD_HOME = 3'd1;
    localparam logic [2:0] CMD_FWD  = 3'd2;
    localparam logic [2:0] CMD_REV  = 3'd3;
    localparam logic [2:0] CMD_AUTO = 3'd4;
    localparam logic [2:0] CMD_STOP = 3'd5;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_HOMING_SPEED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FWD_JOG_SPEED  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REV_JOG_SPEED  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AUTO_SPEED     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AUTO_SETPOINT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HOMING_LIMIT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FWD_LIMIT      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_AUTO_LIMIT     = 3'd7;

    localparam int unsigned CFG_DATA_W = 32;

    // Reset values of the configuration registers, and the tick counter ceiling.
    localparam logic signed [31:0] AUTO_SETPOINT_RESET = 32'sd655360;
    localparam logic [15:0]        LIMIT_TICKS_RESET   = 16'd100;
    localparam logic [15:0]        TICK_MAX            = 16'hFFFF;

    // Current register file contents.
    typedef struct packed {
        logic signed [15:0] homing_speed;
        logic signed [15:0] forward_jog_speed;
        logic signed [15:0] reverse_jog_speed;
        logic signed [15:0] auto_speed;
        logic signed [31:0] auto_setpoint;
        logic        [15:0] homing_limit_ticks;
        logic        [15:0] forward_limit_ticks;
        logic        [15:0] auto_limit_ticks;
    } cfg_t;

    // One control tick.
    typedef struct packed {
        logic               new_command;
        logic        [2:0]  command;
        logic               limit_switch;
        logic signed [31:0] position;
    } tick_t;

    // One result item.
    typedef struct packed {
        logic signed [15:0] drive;
        logic               brake;
        logic               zero_position;
        logic        [2:0]  mode;
        logic               bad_command;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/mhj_if.sv =====
`default_nettype none

// Control tick channel.
interface mhj_in_if;
    logic               valid;
    logic               ready;
    logic               new_command;
    logic        [2:0]  command;
    logic               limit_switch;
    logic signed [31:0] position;

    modport source (output valid, new_command, command, limit_switch, position,
                    input ready);
    modport sink   (input valid, new_command, command, limit_switch, position,
                    output ready);
endinterface

// Result channel.
interface mhj_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] drive;
    logic               brake;
    logic               zero_position;
    logic        [2:0]  mode;
    logic               bad_command;

    modport source (output valid, drive, brake, zero_position, mode, bad_command,
                    input ready);
    modport sink   (input valid, drive, brake, zero_position, mode, bad_command,
                    output ready);
endinterface

// Configuration write channel.
interface mhj_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  reg_index;
    logic [31:0] wdata;

    modport source (output valid, reg_index, wdata, input ready);
    modport sink   (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/motor_homing_jog_sequencer_top.sv =====
`default_nettype none

// Channel   Role    Payload
// in_ch     sink    new_command, command, limit_switch, position
// out_ch    source  drive, brake, zero_position, mode, bad_command
// cfg_ch    sink    reg_index, wdata (always ready)
//
// One tick is accepted per cycle unless the input stalls; its result is offered on out_ch
// after passing through the tick register and then the result register.
// The sequencer state is computed by combinational compare and select logic.
// Reset brings the sequencer to start mode with brake on and the config registers at defaults.
// A stalled result holds its register; the tick register keeps filling, and input
// stalls once both registers hold a transaction.

module motor_homing_jog_sequencer_top #(
    parameter int unsigned REVERSE_LIMIT_TICKS = 100
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    mhj_in_if.sink     in_ch,
    mhj_out_if.source  out_ch,
    mhj_cfg_if.sink    cfg_ch
);
    import mhj_pkg::*;

    cfg_t    cfg;
    tick_t   tick_reg;
    logic    tick_valid_reg;
    result_t result;
    result_t out_reg;
    logic    out_valid_reg;
    logic    out_free;
    logic    advance;

    // Configuration register file.
    assign cfg_ch.ready = 1'b1;

    mhj_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_ch.valid),
        .wr_index (cfg_ch.reg_index),
        .wr_data  (cfg_ch.wdata),
        .cfg      (cfg)
    );

    // Pipeline flow control.
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign advance     = tick_valid_reg && out_free;
    assign in_ch.ready = !tick_valid_reg || out_free;

    // Tick register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            tick_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            tick_reg.new_command  <= in_ch.new_command;
            tick_reg.command      <= in_ch.command;
            tick_reg.limit_switch <= in_ch.limit_switch;
            tick_reg.position     <= in_ch.position;
        end
    end

    // Sequencer.
    mhj_seq #(
        .REVERSE_LIMIT_TICKS (REVERSE_LIMIT_TICKS)
    ) u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .step   (advance),
        .tick   (tick_reg),
        .result (result)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= tick_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= result;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.drive         = out_reg.drive;
    assign out_ch.brake         = out_reg.brake;
    assign out_ch.zero_position = out_reg.zero_position;
    assign out_ch.mode          = out_reg.mode;
    assign out_ch.bad_command   = out_reg.bad_command;

`ifndef SYNTHESIS
    // Homing ends in idle, so the strobe only comes with idle mode.
    a_zero_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.zero_position |-> out_reg.mode == MODE_IDLE)
        else $error("zero_position outside idle");

    // An unknown command is only reported while idle.
    a_bad_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.bad_command |-> out_reg.mode == MODE_IDLE)
        else $error("bad_command outside idle");

    // Brake is only applied with zero drive.
    a_brake_zero_drive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.brake |-> out_reg.drive == 16'sd0)
        else $error("brake with nonzero drive");

    // A tick moved into the sequencer shows up in the result register next cycle.
    a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result lost after advance");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/mhj_cfg_regs.sv =====
`default_nettype none

module mhj_cfg_regs (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            wr_en,
    input  wire logic [mhj_pkg::CFG_IDX_W-1:0]   wr_index,
    input  wire logic [mhj_pkg::CFG_DATA_W-1:0]  wr_data,
    output mhj_pkg::cfg_t                        cfg
);
    import mhj_pkg::*;

    cfg_t cfg_reg;

    // Register file write decode.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.homing_speed        <= '0;
            cfg_reg.forward_jog_speed   <= '0;
            cfg_reg.reverse_jog_speed   <= '0;
            cfg_reg.auto_speed          <= '0;
            cfg_reg.auto_setpoint       <= AUTO_SETPOINT_RESET;
            cfg_reg.homing_limit_ticks  <= LIMIT_TICKS_RESET;
            cfg_reg.forward_limit_ticks <= LIMIT_TICKS_RESET;
            cfg_reg.auto_limit_ticks    <= LIMIT_TICKS_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_HOMING_SPEED:  cfg_reg.homing_speed        <= wr_data[15:0];
                REG_FWD_JOG_SPEED: cfg_reg.forward_jog_speed   <= wr_data[15:0];
                REG_REV_JOG_SPEED: cfg_reg.reverse_jog_speed   <= wr_data[15:0];
                REG_AUTO_SPEED:    cfg_reg.auto_speed          <= wr_data[15:0];
                REG_AUTO_SETPOINT: cfg_reg.auto_setpoint       <= wr_data[31:0];
                REG_HOMING_LIMIT:  cfg_reg.homing_limit_ticks  <= wr_data[15:0];
                REG_FWD_LIMIT:     cfg_reg.forward_limit_ticks <= wr_data[15:0];
                REG_AUTO_LIMIT:    cfg_reg.auto_limit_ticks    <= wr_data[15:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/core/mhj_seq.sv =====
`default_nettype none

module mhj_seq #(
    parameter int unsigned REVERSE_LIMIT_TICKS = 100
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire mhj_pkg::cfg_t    cfg,
    input  wire logic             step,
    input  wire mhj_pkg::tick_t   tick,
    output mhj_pkg::result_t      result
);
    import mhj_pkg::*;

    localparam logic [15:0] REV_LIMIT = 16'(REVERSE_LIMIT_TICKS);

    mode_t              mode_reg,    mode_next;
    logic        [2:0]  cmd_reg,     cmd_next;
    logic        [15:0] tick_reg,    tick_next;
    logic signed [15:0] drive_reg,   drive_next;
    logic               brake_reg,   brake_next;

    logic        [2:0]  cmd_cur;
    mode_t              mode_cur;
    logic        [15:0] tick_inc;
    logic        [15:0] tick_limit;
    logic               past_setpoint;
    logic               timed_out;
    logic               stop_cmd;
    logic               move_done;

    // Command latch and start-to-idle step happen before the mode decision.
    assign cmd_cur  = tick.new_command ? tick.command : cmd_reg;
    assign mode_cur = (mode_reg == MODE_START) ? MODE_IDLE : mode_reg;

    assign past_setpoint = tick.position >= cfg.auto_setpoint;
    assign stop_cmd      = cmd_cur == CMD_STOP;
    assign tick_inc      = (tick_reg == TICK_MAX) ? tick_reg : tick_reg + 16'd1;
    assign timed_out     = tick_inc >= tick_limit;

    // Timeout limit and exit condition of the current moving mode.
    always_comb
    begin
        tick_limit = cfg.auto_limit_ticks;
        move_done  = 1'b0;
        case (mode_cur)
            MODE_HOME:
            begin
                tick_limit = cfg.homing_limit_ticks;
                move_done  = tick.limit_switch || timed_out;
            end
            MODE_FWD:
            begin
                tick_limit = cfg.forward_limit_ticks;
                move_done  = stop_cmd || timed_out;
            end
            MODE_REV:
            begin
                tick_limit = REV_LIMIT;
                move_done  = stop_cmd || tick.limit_switch || timed_out;
            end
            MODE_AUTO:
            begin
                tick_limit = cfg.auto_limit_ticks;
                move_done  = past_setpoint || timed_out;
            end
            default:
            begin
                tick_limit = cfg.auto_limit_ticks;
                move_done  = 1'b0;
            end
        endcase
    end

    // Next state of the sequencer.
    always_comb
    begin
        mode_next  = mode_cur;
        cmd_next   = cmd_cur;
        tick_next  = tick_reg;
        drive_next = drive_reg;
        brake_next = brake_reg;
        unique case (mode_cur)
            MODE_IDLE:
            begin
                unique case (cmd_cur) inside
                    CMD_HOME:
                    begin
                        if (tick.limit_switch)
                        begin
                            cmd_next = CMD_NONE;
                        end
                        else
                        begin
                            mode_next  = MODE_HOME;
                            tick_next  = '0;
                            drive_next = cfg.homing_speed;
                            brake_next = 1'b0;
                        end
                    end
                    CMD_FWD:
                    begin
                        if (tick.limit_switch)
                        begin
                            cmd_next = CMD_NONE;
                        end
                        else
                        begin
                            mode_next  = MODE_FWD;
                            tick_next  = '0;
                            drive_next = cfg.forward_jog_speed;
                            brake_next = 1'b0;
                        end
                    end
                    CMD_REV:
                    begin
                        if (tick.limit_switch)
                        begin
                            cmd_next = CMD_NONE;
                        end
                        else
                        begin
                            mode_next  = MODE_REV;
                            tick_next  = '0;
                            drive_next = cfg.reverse_jog_speed;
                            brake_next = 1'b0;
                        end
                    end
                    CMD_AUTO:
                    begin
                        if (tick.limit_switch || past_setpoint)
                        begin
                            cmd_next = CMD_NONE;
                        end
                        else
                        begin
                            mode_next  = MODE_AUTO;
                            tick_next  = '0;
                            drive_next = cfg.auto_speed;
                            brake_next = 1'b0;
                        end
                    end
                    default:
                    begin
                        // None, stop and unknown codes leave everything as is.
                        cmd_next = cmd_cur;
                    end
                endcase
            end
            MODE_HOME, MODE_FWD, MODE_REV, MODE_AUTO:
            begin
                tick_next = tick_inc;
                if (move_done)
                begin
                    mode_next  = MODE_IDLE;
                    cmd_next   = CMD_NONE;
                    drive_next = '0;
                    brake_next = 1'b1;
                end
            end
            default:
            begin
                // Unreachable mode codes hold all state.
                mode_next = mode_cur;
            end
        endcase
    end

    // Result of the tick, taken after the update.
    always_comb
    begin
        result.drive         = drive_next;
        result.brake         = brake_next;
        result.mode          = mode_next;
        result.zero_position = (mode_cur == MODE_HOME) && move_done;
        result.bad_command   = (mode_cur == MODE_IDLE) &&
                               (cmd_cur != CMD_NONE) && (cmd_cur != CMD_HOME) &&
                               (cmd_cur != CMD_FWD)  && (cmd_cur != CMD_REV)  &&
                               (cmd_cur != CMD_AUTO) && (cmd_cur != CMD_STOP);
    end

    // State registers advance once per tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_START;
            cmd_reg   <= CMD_NONE;
            tick_reg  <= '0;
            drive_reg <= '0;
            brake_reg <= 1'b1;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            cmd_reg   <= cmd_next;
            tick_reg  <= tick_next;
            drive_reg <= drive_next;
            brake_reg <= brake_next;
        end
    end

endmodule

`default_nettype wire
